@@ rtl/core/i2cm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared command codes, status codes, register indexes and the structs
// that travel between the sequencer, the output stage and the top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NACK     = 2'd1;
  localparam logic [1:0] ST_BUS_BUSY = 2'd2;

  localparam logic CFG_PHASE_TICKS  = 1'b0;
  localparam logic CFG_STOP_ON_NACK = 1'b1;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
  localparam logic [7:0]  BYTE_MSB        = 8'h80;

  // Bus phase numbers inside a byte transfer.
  localparam logic [4:0] PH_ACK_HIGH = 5'd17;
  localparam logic [4:0] PH_ACK_LAST = 5'd18;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic        stop_on_nack;
  } cfg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic [1:0] status;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/i2cm_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master bus phase sequencer
// Holds the command state and advances it by one base-clock tick for every
// accepted input item, producing that tick's line levels and status.
// ----------------------------------------------------------------------------
module i2cm_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step_en,
  input  wire i2cm_pkg::cfg_t cfg,
  input  wire logic [2:0]     opcode,
  input  wire logic [7:0]     data_byte,
  input  wire logic           send_ack,
  input  wire logic           sda_in,
  output i2cm_pkg::res_t      res
);

  i2cm_pkg::op_t active_r, active_nxt;
  logic [4:0]    phase_r, phase_nxt;
  logic [3:0]    bitc_r, bitc_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [15:0]   wait_r, wait_nxt;
  logic          scl_r, scl_nxt;
  logic          sda_r, sda_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          ackd_r, ackd_nxt;
  logic [7:0]    rbyte_r, rbyte_nxt;
  logic          nstop_r, nstop_nxt;

  i2cm_pkg::op_t op_in;
  i2cm_pkg::op_t cmd;
  logic          start;
  logic [15:0]   len;
  logic          fin;
  logic          restart;
  logic          odd_bit;

  always_comb begin
    op_in = i2cm_pkg::op_t'(opcode);
    start = (active_r == i2cm_pkg::OP_NONE) && (opcode != 3'(i2cm_pkg::OP_NONE)) &&
            (opcode <= 3'(i2cm_pkg::OP_READ));
    len   = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;

    cmd        = start ? op_in : active_r;
    active_nxt = cmd;
    phase_nxt  = start ? 5'd0 : phase_r;
    bitc_nxt   = start ? 4'd0 : bitc_r;
    wait_nxt   = start ? 16'd0 : wait_r;
    shift_nxt  = (start && op_in == i2cm_pkg::OP_WRITE) ? data_byte : shift_r;
    ackd_nxt   = (start && op_in == i2cm_pkg::OP_READ) ? send_ack : ackd_r;
    rbyte_nxt  = (start && op_in == i2cm_pkg::OP_READ) ? 8'd0 : rbyte_r;
    nstop_nxt  = start ? 1'b0 : nstop_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    status_nxt = status_r;
    fin        = 1'b0;
    restart    = 1'b0;
    odd_bit    = (phase_nxt < 5'd16) && phase_nxt[0];

    res.busy_res = 1'b0;
    res.done_res = 1'b0;

    if (cmd != i2cm_pkg::OP_NONE) begin
      res.busy_res = 1'b1;

      // Line levels for the current phase.
      unique case (cmd)
        i2cm_pkg::OP_START: begin
          scl_nxt = phase_nxt < 5'd3;
          sda_nxt = phase_nxt < 5'd2;
        end
        i2cm_pkg::OP_STOP: begin
          scl_nxt = phase_nxt != 5'd0;
          sda_nxt = phase_nxt == 5'd2;
        end
        i2cm_pkg::OP_WRITE: begin
          if (phase_nxt < 5'd16) begin
            scl_nxt = phase_nxt[0];
            sda_nxt = |(shift_nxt & (i2cm_pkg::BYTE_MSB >> bitc_nxt[2:0]));
          end else begin
            scl_nxt = phase_nxt == i2cm_pkg::PH_ACK_HIGH;
            sda_nxt = 1'b1;
          end
        end
        default: begin
          if (phase_nxt < 5'd16) begin
            scl_nxt = phase_nxt[0];
            sda_nxt = 1'b1;
          end else begin
            scl_nxt = phase_nxt == i2cm_pkg::PH_ACK_HIGH;
            sda_nxt = !ackd_nxt;
          end
        end
      endcase

      wait_nxt = wait_nxt + 16'd1;
      if (wait_nxt >= len) begin
        wait_nxt = 16'd0;
        unique case (cmd)
          i2cm_pkg::OP_START: begin
            if (phase_nxt == 5'd1 && !sda_in) begin
              status_nxt = i2cm_pkg::ST_BUS_BUSY;
              fin        = 1'b1;
            end else if (phase_nxt == 5'd3) begin
              status_nxt = i2cm_pkg::ST_OK;
              fin        = 1'b1;
            end
          end
          i2cm_pkg::OP_STOP: begin
            if (phase_nxt == 5'd2) begin
              status_nxt = nstop_nxt ? i2cm_pkg::ST_NACK : i2cm_pkg::ST_OK;
              nstop_nxt  = 1'b0;
              fin        = 1'b1;
            end
          end
          i2cm_pkg::OP_WRITE: begin
            if (odd_bit) bitc_nxt = bitc_nxt + 4'd1;
            if (phase_nxt == i2cm_pkg::PH_ACK_HIGH) ackd_nxt = !sda_in;
            if (phase_nxt == i2cm_pkg::PH_ACK_LAST) begin
              if (ackd_nxt) begin
                status_nxt = i2cm_pkg::ST_OK;
                fin        = 1'b1;
              end else begin
                status_nxt = i2cm_pkg::ST_NACK;
                if (cfg.stop_on_nack) begin
                  // A refused byte chains straight into a STOP.
                  nstop_nxt  = 1'b1;
                  active_nxt = i2cm_pkg::OP_STOP;
                  phase_nxt  = 5'd0;
                  bitc_nxt   = 4'd0;
                  restart    = 1'b1;
                end else begin
                  fin = 1'b1;
                end
              end
            end
          end
          default: begin
            if (odd_bit) begin
              rbyte_nxt = {rbyte_nxt[6:0], sda_in};
              bitc_nxt  = bitc_nxt + 4'd1;
            end
            if (phase_nxt == i2cm_pkg::PH_ACK_LAST) begin
              status_nxt = i2cm_pkg::ST_OK;
              fin        = 1'b1;
            end
          end
        endcase
        if (!fin && !restart) phase_nxt = phase_nxt + 5'd1;
      end
    end

    if (fin && cmd == i2cm_pkg::OP_START && status_nxt == i2cm_pkg::ST_BUS_BUSY) begin
      scl_nxt = 1'b1;
      sda_nxt = 1'b1;
    end

    res.scl_level   = scl_nxt;
    res.sda_release = sda_nxt;
    res.read_value  = rbyte_nxt;
    res.status      = status_nxt;

    if (fin) begin
      res.done_res = 1'b1;
      // The read's acknowledge level is released once the transfer ends.
      if (cmd == i2cm_pkg::OP_READ) sda_nxt = 1'b1;
      active_nxt = i2cm_pkg::OP_NONE;
      phase_nxt  = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= i2cm_pkg::OP_NONE;
      phase_r  <= 5'd0;
      bitc_r   <= 4'd0;
      shift_r  <= 8'd0;
      wait_r   <= 16'd0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      status_r <= i2cm_pkg::ST_OK;
      ackd_r   <= 1'b0;
      rbyte_r  <= 8'd0;
      nstop_r  <= 1'b0;
    end else if (step_en) begin
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      bitc_r   <= bitc_nxt;
      shift_r  <= shift_nxt;
      wait_r   <= wait_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      status_r <= status_nxt;
      ackd_r   <= ackd_nxt;
      rbyte_r  <= rbyte_nxt;
      nstop_r  <= nstop_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/i2cm_obuf.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master result register
// Holds one result until the output transfer completes; a new result can
// be loaded in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
module i2cm_obuf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire i2cm_pkg::res_t res_in,
  output logic                can_load,
  output logic                out_valid,
  input  wire logic           out_ready,
  output i2cm_pkg::res_t      res_out
);

  logic           valid_r, valid_nxt;
  i2cm_pkg::res_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign res_out   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_in;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/i2c_master_byte_engine_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master byte engine
// Top level: configuration registers, phase sequencer and result register.
// ----------------------------------------------------------------------------
// Each input transfer is one base-clock tick of the bus engine and yields
// exactly one result transfer carrying SCL, SDA, busy, done, the last byte
// read and the status. A tick is taken every cycle while the result register
// can load: the sequencer updates its state in one pass and the result is
// held in an output register, so the result is registered and the next tick
// is accepted in the same cycle the previous result leaves. Opcodes are
// looked at only while no command runs. phase_ticks sets the ticks per half
// bit (0 acts as 1); write the configuration only while the engine is idle.
module i2c_master_byte_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_send_ack,
  input  wire logic        in_sda_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_scl_level,
  output logic             out_sda_release,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [7:0]       out_read_value,
  output logic [1:0]       out_status
);

  i2cm_pkg::cfg_t cfg_r;
  i2cm_pkg::res_t step_res;
  i2cm_pkg::res_t held_res;
  logic           can_load;
  logic           step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_ticks  <= i2cm_pkg::PHASE_TICKS_RST;
      cfg_r.stop_on_nack <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cm_pkg::CFG_PHASE_TICKS:  cfg_r.phase_ticks  <= cfg_wdata;
        i2cm_pkg::CFG_STOP_ON_NACK: cfg_r.stop_on_nack <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_ready = can_load;
  assign step_en  = in_valid && can_load;

  i2cm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .cfg       (cfg_r),
    .opcode    (in_opcode),
    .data_byte (in_data_byte),
    .send_ack  (in_send_ack),
    .sda_in    (in_sda_in),
    .res       (step_res)
  );

  i2cm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .res_in    (step_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (held_res)
  );

  assign out_scl_level   = held_res.scl_level;
  assign out_sda_release = held_res.sda_release;
  assign out_busy_res    = held_res.busy_res;
  assign out_done_res    = held_res.done_res;
  assign out_read_value  = held_res.read_value;
  assign out_status      = held_res.status;

  // A completed command always reports itself as busy on its last tick.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_busy_res)
    else $error("done without busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  // A START refused for a busy bus leaves both lines released.
  a_busy_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res && out_status == i2cm_pkg::ST_BUS_BUSY
      |-> out_scl_level && out_sda_release)
    else $error("lines held after bus-busy start");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule
`default_nettype wire
